>>> rtl/core/pds_pkg.sv
// shared constants, widths, config struct and word packing for the divider search
package pds_pkg;

  localparam int unsigned POSDIV_MAX = 7;
  localparam int unsigned REFDIV_MAX = 2;

  localparam int unsigned TARGET_W   = 19;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned ACTUAL_W   = 19;
  localparam int unsigned REF_W      = 7;
  localparam int unsigned MHZ_W      = 12;
  localparam int unsigned FB_W       = 12;
  localparam int unsigned TOL_W      = 17;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned SCALE     = 100;
  localparam int unsigned ROUND_NUM = 51;

  // loop counters: r in 1..REFDIV_MAX, p1 in 0..POSDIV_MAX, p2 (divider plus one) in 1..p1+1
  localparam int unsigned R_W  = $clog2(REFDIV_MAX + 1);
  localparam int unsigned P1_W = (POSDIV_MAX < 1) ? 1 : $clog2(POSDIV_MAX + 1);
  localparam int unsigned P2_W = $clog2(POSDIV_MAX + 2);

  localparam int unsigned M_MAX = (POSDIV_MAX + 1) * (POSDIV_MAX + 1);
  localparam int unsigned M_W   = $clog2(M_MAX + 1);
  localparam int unsigned RM_W  = $clog2(REFDIV_MAX * M_MAX + 1);

  localparam int unsigned X_W    = TARGET_W + RM_W;
  localparam int unsigned VCO_W  = $clog2((2**REF_W - 1) * (2**FB_W - 1) + 1);
  localparam int unsigned GOT_W  = $clog2(SCALE * (2**REF_W - 1) * (2**FB_W - 1) + 1);
  localparam int unsigned DIV_W  = (X_W > GOT_W) ? X_W : GOT_W;
  localparam int unsigned D100_W = $clog2(SCALE * (2**REF_W - 1) + 1);
  localparam int unsigned DVS_W  = (D100_W > RM_W) ? D100_W : RM_W;
  localparam int unsigned LIM_W  = VCO_W;
  localparam int unsigned VR_W   = MHZ_W + R_W;
  localparam int unsigned VC_W   = (VCO_W > VR_W) ? VCO_W : VR_W;
  localparam int unsigned TOLR_W = TOL_W + RM_W;
  localparam int unsigned FBX_W  = DIV_W + 1;

  localparam logic [WORD_W-1:0]   DEFAULT_WORD = 32'hC054_0165;
  localparam logic [ACTUAL_W-1:0] ACTUAL_MAX   = 19'h7FFFF;

  localparam logic [REF_W-1:0] RST_REF_FREQ  = 7'd25;
  localparam logic [MHZ_W-1:0] RST_VCO_MIN   = 12'd2000;
  localparam logic [MHZ_W-1:0] RST_VCO_MAX   = 12'd3200;
  localparam logic [FB_W-1:0]  RST_FBDIV_MIN = 12'd16;
  localparam logic [FB_W-1:0]  RST_FBDIV_MAX = 12'd250;
  localparam logic [MHZ_W-1:0] RST_VCO_HIGH  = 12'd2400;
  localparam logic [TOL_W-1:0] RST_TOLERANCE = 17'd300;

  typedef enum logic [CFG_IDX_W-1:0] {
    IDX_REF_FREQ  = 3'd0,
    IDX_VCO_MIN   = 3'd1,
    IDX_VCO_MAX   = 3'd2,
    IDX_FBDIV_MIN = 3'd3,
    IDX_FBDIV_MAX = 3'd4,
    IDX_VCO_HIGH  = 3'd5,
    IDX_TOLERANCE = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [REF_W-1:0] ref_freq_mhz;
    logic [MHZ_W-1:0] vco_min_mhz;
    logic [MHZ_W-1:0] vco_max_mhz;
    logic [FB_W-1:0]  fbdiv_min;
    logic [FB_W-1:0]  fbdiv_max;
    logic [MHZ_W-1:0] vco_high_threshold;
    logic [TOL_W-1:0] tolerance_centi;
  } cfg_t;

  function automatic logic [WORD_W-1:0] pack_word(input logic vsel, input logic [FB_W-1:0] fb,
                                                  input logic [5:0] r, input logic [2:0] p1,
                                                  input logic [2:0] p2);
    logic [WORD_W-1:0] w;
    w = 32'hC000_0000;
    w[28]    = vsel;
    w[27:16] = fb;
    w[13:8]  = r;
    w[6:4]   = p1;
    w[2:0]   = p2;
    return w;
  endfunction

endpackage

>>> rtl/core/pll_divider_search_unit.sv
// top level of the pll divider search unit
//
//   channel   direction  handshake                 word
//   cfg       in         cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_wdata_i
//   in        in         in_valid_i / in_ready_o    target_freq_i
//   out       out        out_valid_o / out_ready_i  control_word_o, actual_freq_o, found_o
//
// a candidate runs the 27-step divider on x / (100 ref) and stops at S_VCO when the feedback
// limits reject it, at S_CHECK when the vco checks do; a hit runs it again for got / (r m)
// a zero reference ends the search after S_PREP; otherwise it runs through all 72
// candidates, or ends at the first hit
// in_ready_o is low until the result moves into the output register, which holds it
// while the next word is accepted; reset restores config defaults, cfg_ready_o stays high
module pll_divider_search_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pds_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pds_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [pds_pkg::TARGET_W-1:0]   target_freq_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [pds_pkg::WORD_W-1:0]     control_word_o,
  output logic [pds_pkg::ACTUAL_W-1:0]   actual_freq_o,
  output logic                           found_o
);
  import pds_pkg::*;

  cfg_t cfg;

  assign cfg_ready_o = 1'b1;

  pds_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  pds_search_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .target_freq_i  (target_freq_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .control_word_o (control_word_o),
    .actual_freq_o  (actual_freq_o),
    .found_o        (found_o)
  );

endmodule

>>> rtl/core/pds_cfg_regs.sv
// configuration register file with write channel
module pds_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [pds_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pds_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output pds_pkg::cfg_t                  cfg_o
);
  import pds_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        IDX_REF_FREQ:  cfg_d.ref_freq_mhz       = cfg_wdata_i[REF_W-1:0];
        IDX_VCO_MIN:   cfg_d.vco_min_mhz        = cfg_wdata_i[MHZ_W-1:0];
        IDX_VCO_MAX:   cfg_d.vco_max_mhz        = cfg_wdata_i[MHZ_W-1:0];
        IDX_FBDIV_MIN: cfg_d.fbdiv_min          = cfg_wdata_i[FB_W-1:0];
        IDX_FBDIV_MAX: cfg_d.fbdiv_max          = cfg_wdata_i[FB_W-1:0];
        IDX_VCO_HIGH:  cfg_d.vco_high_threshold = cfg_wdata_i[MHZ_W-1:0];
        IDX_TOLERANCE: cfg_d.tolerance_centi    = cfg_wdata_i[TOL_W-1:0];
        default: ;  // unknown index is dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ref_freq_mhz       <= RST_REF_FREQ;
      cfg_q.vco_min_mhz        <= RST_VCO_MIN;
      cfg_q.vco_max_mhz        <= RST_VCO_MAX;
      cfg_q.fbdiv_min          <= RST_FBDIV_MIN;
      cfg_q.fbdiv_max          <= RST_FBDIV_MAX;
      cfg_q.vco_high_threshold <= RST_VCO_HIGH;
      cfg_q.tolerance_centi    <= RST_TOLERANCE;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/core/pds_divider.sv
// restoring divider, one quotient bit per cycle
module pds_divider (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [pds_pkg::DIV_W-1:0] dividend_i,
  input  logic [pds_pkg::DVS_W-1:0] divisor_i,
  output logic                      busy_o,
  output logic [pds_pkg::DIV_W-1:0] quotient_o,
  output logic [pds_pkg::DVS_W-1:0] remainder_o
);
  import pds_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_W + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  // shift register holds the remaining dividend bits and collects quotient bits
  always_comb begin
    trial = {rem_q, quo_q[DIV_W-1]};
    diff  = trial - {1'b0, dvs_q};
    ge    = (trial >= {1'b0, dvs_q});
    rem_d = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    quo_d = {quo_q[DIV_W-2:0], ge};
    cnt_d = cnt_q - CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CNT_W'(DIV_W);
    end else if (busy_o) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_o) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o      = (cnt_q != '0);
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

>>> rtl/core/pds_search_ctrl.sv
// search sequencer: walks divider settings, checks limits and error, holds the result word
module pds_search_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pds_pkg::cfg_t                cfg_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [pds_pkg::TARGET_W-1:0] target_freq_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [pds_pkg::WORD_W-1:0]   control_word_o,
  output logic [pds_pkg::ACTUAL_W-1:0] actual_freq_o,
  output logic                         found_o
);
  import pds_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE   = 14'h0001,
    S_PREP   = 14'h0002,
    S_MCALC  = 14'h0004,
    S_RMCALC = 14'h0008,
    S_XCALC  = 14'h0010,
    S_DIVS   = 14'h0020,
    S_DIVW   = 14'h0040,
    S_FBCALC = 14'h0080,
    S_VCO    = 14'h0100,
    S_CHECK  = 14'h0200,
    S_ERR    = 14'h0400,
    S_ACTS   = 14'h0800,
    S_ACTW   = 14'h1000,
    S_NEXT   = 14'h2000
  } state_e;

  state_e state_q, state_d;

  logic [R_W-1:0]  r_q;
  logic [P1_W-1:0] p1_q;
  logic [P2_W-1:0] p2_q;
  logic            hit_q;
  logic            done_q;
  logic            out_valid_q;

  logic [TARGET_W-1:0] target_q;
  logic [D100_W-1:0]   d100_q;
  logic [D100_W-1:0]   h51_q;
  logic [LIM_W-1:0]    lim_q;
  logic [M_W-1:0]      m_q;
  logic [RM_W-1:0]     rm_q;
  logic [VR_W-1:0]     vmin_r_q;
  logic [VR_W-1:0]     vmax_r_q;
  logic [VR_W-1:0]     thr_r_q;
  logic [X_W-1:0]      x_q;
  logic [TOLR_W-1:0]   tolr_q;
  logic [FBX_W-1:0]    fb_q;
  logic [VCO_W-1:0]    vco_q;
  logic [GOT_W-1:0]    got_q;
  logic [WORD_W-1:0]   word_q;
  logic [ACTUAL_W-1:0] act_q;

  logic [WORD_W-1:0]   cw_q;
  logic [ACTUAL_W-1:0] af_q;
  logic                fd_q;

  logic             div_start;
  logic             div_busy;
  logic [DIV_W-1:0] div_dividend;
  logic [DVS_W-1:0] div_divisor;
  logic [DIV_W-1:0] div_quo;
  logic [DVS_W-1:0] div_rem;

  logic             fb_bad;
  logic             r1_cap;
  logic             in_range;
  logic             vsel;
  logic [DIV_W-1:0] got_x;
  logic [DIV_W-1:0] err;
  logic             is_hit;
  logic             last_cand;
  logic             in_acc;
  logic             out_load;

  assign div_start    = (state_q == S_DIVS) || (state_q == S_ACTS);
  assign div_dividend = (state_q == S_ACTS) ? DIV_W'(got_q) : DIV_W'(x_q);
  assign div_divisor  = (state_q == S_ACTS) ? DVS_W'(rm_q) : DVS_W'(d100_q);

  pds_divider u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .busy_o      (div_busy),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  always_comb begin
    fb_bad   = (fb_q > FBX_W'(cfg_i.fbdiv_max)) || (fb_q < FBX_W'(cfg_i.fbdiv_min));
    r1_cap   = (r_q == R_W'(1)) && ({vco_q, 1'b0} > (VCO_W + 1)'(lim_q));
    in_range = (VC_W'(vco_q) <= VC_W'(vmax_r_q)) && (VC_W'(vco_q) >= VC_W'(vmin_r_q));
    vsel     = (VC_W'(vco_q) > VC_W'(thr_r_q));
    got_x    = DIV_W'(got_q);
    err      = (got_x > DIV_W'(x_q)) ? (got_x - DIV_W'(x_q)) : (DIV_W'(x_q) - got_x);
    is_hit   = (err < DIV_W'(tolr_q));
    last_cand = (p2_q == P2_W'(1)) && (p1_q == P1_W'(POSDIV_MAX)) && (r_q == R_W'(1));
    in_acc   = in_valid_i && in_ready_o;
    out_load = done_q && (!out_valid_q || out_ready_i);
  end

  // done_q marks the hand-off to the output register, S_NEXT advances the counters
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_acc) state_d = S_PREP;
      S_PREP:   state_d = (cfg_i.ref_freq_mhz == '0) ? S_IDLE : S_MCALC;
      S_MCALC:  state_d = S_RMCALC;
      S_RMCALC: state_d = S_XCALC;
      S_XCALC:  state_d = S_DIVS;
      S_DIVS:   state_d = S_DIVW;
      S_DIVW:   if (!div_busy) state_d = S_FBCALC;
      S_FBCALC: state_d = S_VCO;
      S_VCO:    state_d = fb_bad ? S_NEXT : S_CHECK;
      S_CHECK:  state_d = (r1_cap || !in_range) ? S_NEXT : S_ERR;
      S_ERR:    state_d = is_hit ? S_ACTS : S_NEXT;
      S_ACTS:   state_d = S_ACTW;
      S_ACTW:   if (!div_busy) state_d = S_IDLE;
      S_NEXT:   state_d = last_cand ? S_IDLE : S_MCALC;
      default:  state_d = S_IDLE;
    endcase
    // a finished search waits in idle with done set until the output register frees up
    if (done_q) state_d = out_load ? S_IDLE : state_q;
  end

  assign in_ready_o = (state_q == S_IDLE) && !done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      r_q         <= R_W'(REFDIV_MAX);
      p1_q        <= '0;
      p2_q        <= P2_W'(1);
      hit_q       <= 1'b0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        r_q   <= R_W'(REFDIV_MAX);
        p1_q  <= '0;
        p2_q  <= P2_W'(1);
        hit_q <= 1'b0;
      end
      if (state_q == S_NEXT && !last_cand) begin
        if (p2_q != P2_W'(1)) begin
          p2_q <= p2_q - P2_W'(1);
        end else if (p1_q != P1_W'(POSDIV_MAX)) begin
          p1_q <= p1_q + P1_W'(1);
          p2_q <= P2_W'(p1_q) + P2_W'(2);
        end else begin
          r_q  <= r_q - R_W'(1);
          p1_q <= '0;
          p2_q <= P2_W'(1);
        end
      end
      if (state_q == S_ERR && is_hit) hit_q <= 1'b1;
      // search finishes: zero reference, hit division done, or candidates exhausted
      if ((state_q == S_PREP && cfg_i.ref_freq_mhz == '0) ||
          (state_q == S_ACTW && !div_busy) ||
          (state_q == S_NEXT && last_cand)) begin
        done_q <= 1'b1;
      end else if (out_load) begin
        done_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      target_q <= target_freq_i;
      word_q   <= DEFAULT_WORD;
      act_q    <= '0;
    end
    if (state_q == S_PREP) begin
      d100_q <= D100_W'(D100_W'(cfg_i.ref_freq_mhz) * D100_W'(SCALE));
      h51_q  <= D100_W'(D100_W'(cfg_i.ref_freq_mhz) * D100_W'(ROUND_NUM));
      lim_q  <= LIM_W'(LIM_W'(cfg_i.fbdiv_max) * LIM_W'(cfg_i.ref_freq_mhz));
    end
    if (state_q == S_MCALC) begin
      m_q <= M_W'((M_W'(p1_q) + M_W'(1)) * M_W'(p2_q));
    end
    if (state_q == S_RMCALC) begin
      rm_q     <= RM_W'(RM_W'(r_q) * RM_W'(m_q));
      vmin_r_q <= VR_W'(VR_W'(cfg_i.vco_min_mhz) * VR_W'(r_q));
      vmax_r_q <= VR_W'(VR_W'(cfg_i.vco_max_mhz) * VR_W'(r_q));
      thr_r_q  <= VR_W'(VR_W'(cfg_i.vco_high_threshold) * VR_W'(r_q));
    end
    if (state_q == S_XCALC) begin
      x_q    <= X_W'(X_W'(target_q) * X_W'(rm_q));
      tolr_q <= TOLR_W'(TOLR_W'(cfg_i.tolerance_centi) * TOLR_W'(rm_q));
    end
    // remainder of x / (100 ref) at or above 51 ref means the hundredths exceed one half
    if (state_q == S_FBCALC) begin
      fb_q <= FBX_W'(div_quo) + FBX_W'(DVS_W'(div_rem) >= DVS_W'(h51_q));
    end
    if (state_q == S_VCO) begin
      vco_q <= VCO_W'(VCO_W'(fb_q[FB_W-1:0]) * VCO_W'(cfg_i.ref_freq_mhz));
    end
    if (state_q == S_CHECK && !r1_cap && in_range) begin
      word_q <= pack_word(vsel, fb_q[FB_W-1:0], 6'(r_q), 3'(p1_q), 3'(p2_q - P2_W'(1)));
      got_q  <= GOT_W'(GOT_W'(vco_q) * GOT_W'(SCALE));
    end
    if (state_q == S_ACTW && !div_busy) begin
      act_q <= (div_quo > DIV_W'(ACTUAL_MAX)) ? ACTUAL_MAX : div_quo[ACTUAL_W-1:0];
    end
    if (out_load) begin
      cw_q <= word_q;
      af_q <= act_q;
      fd_q <= hit_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign control_word_o = cw_q;
  assign actual_freq_o  = af_q;
  assign found_o        = fd_q;

endmodule
